[src/ipd_pkg.sv]
// ----------------------------------------------------------------------------
// ipd_pkg: shared types and constants for the length-prefixed message parser
// Holds the framing characters, register indexes and the result payload type.
// ----------------------------------------------------------------------------
package ipd_pkg;

  localparam int unsigned ByteW = 8;

  // Framing characters of the outer parser.
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChComma = 8'h2C;
  localparam logic [ByteW-1:0] ChColon = 8'h3A;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CfgOnCode  = 1'b0,
    CfgOffCode = 1'b1
  } cfg_idx_e;

  localparam logic [ByteW-1:0] OnCodeRst  = 8'h00;
  localparam logic [ByteW-1:0] OffCodeRst = 8'h01;

  typedef struct packed {
    logic [ByteW-1:0] msg_type;
    logic [ByteW-1:0] msg_length;
    logic             led_on;
  } result_t;

endpackage

[src/ipd_if.sv]
// ----------------------------------------------------------------------------
// ipd_if: valid/ready channels of the length-prefixed message parser
// ipd_in_if carries received link bytes, ipd_out_if carries completed messages.
// ----------------------------------------------------------------------------
interface ipd_in_if;
  logic                     valid;
  logic                     ready;
  logic [ipd_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ipd_out_if;
  logic                     valid;
  logic                     ready;
  logic [ipd_pkg::ByteW-1:0] msg_type;
  logic [ipd_pkg::ByteW-1:0] msg_length;
  logic                     led_on;

  modport source (output valid, output msg_type, output msg_length, output led_on,
                  input ready);
  modport sink   (input valid, input msg_type, input msg_length, input led_on,
                  output ready);
endinterface

[src/ipd_length_prefixed_message_parser.sv]
// ----------------------------------------------------------------------------
// ipd_length_prefixed_message_parser: deframer for length-prefixed messages
// Extracts counted payloads from a byte stream and decodes inner messages.
// ----------------------------------------------------------------------------
// Usage:
// Received link bytes enter on the rx channel, one byte per transfer. Each
// completed inner message leaves on the tx channel as one transfer carrying
// its type (first byte), its length header and the LED state after it was
// handled; bytes that complete no message produce nothing.
// A byte is captured in an input register, then decoded by one pass of
// small logic that updates the parser state and loads the result register.
// A result appears on tx once the byte that completes its message has passed
// through the input register and been loaded into the result register. The
// block takes one byte every cycle while tx does not stall; the pipeline
// moves whenever the result register is empty or being drained, so a stall
// on tx holds one result and one byte, then drops rx.ready.
// Reset puts the outer parser in idle waiting for a carriage return, the
// inner deframer expecting a length header, the LED off, on_code to 0 and
// off_code to 1. The codes are written through cfg_we_i; the user must write
// them only while no byte is in flight, as the block does not enforce this.
// ----------------------------------------------------------------------------
module ipd_length_prefixed_message_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  ipd_in_if.sink                    rx,
  ipd_out_if.source                 tx,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [ipd_pkg::ByteW-1:0] cfg_wdata_i
);

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhSkip    = 2'd1,
    PhCount   = 2'd2,
    PhPayload = 2'd3
  } phase_e;

  logic [ipd_pkg::ByteW-1:0] on_code_q, off_code_q;

  // Input register.
  logic                      byte_vld_q;
  logic [ipd_pkg::ByteW-1:0] byte_q;

  // Parser state.
  phase_e                    phase_q, phase_d;
  logic [ipd_pkg::ByteW-1:0] pay_rem_q, pay_rem_d;
  logic                      exp_hdr_q, exp_hdr_d;
  logic [ipd_pkg::ByteW-1:0] exp_len_q, exp_len_d;
  logic [ipd_pkg::ByteW-1:0] rcv_cnt_q, rcv_cnt_d;
  logic [ipd_pkg::ByteW-1:0] first_q, first_d;
  logic                      led_q, led_d;

  // Result register.
  logic                      res_vld_q;
  ipd_pkg::result_t          res_q, res_d;
  logic                      emit;

  logic                      advance, proc;
  logic [ipd_pkg::ByteW-1:0] rem_dec, cnt_inc, first_now;

  assign advance  = !res_vld_q || tx.ready;
  assign proc     = byte_vld_q && advance;
  assign rx.ready = !byte_vld_q || advance;

  assign rem_dec   = pay_rem_q - 8'd1;
  assign cnt_inc   = rcv_cnt_q + 8'd1;
  assign first_now = (rcv_cnt_q == '0) ? byte_q : first_q;

  always_comb begin
    phase_d   = phase_q;
    pay_rem_d = pay_rem_q;
    exp_hdr_d = exp_hdr_q;
    exp_len_d = exp_len_q;
    rcv_cnt_d = rcv_cnt_q;
    first_d   = first_q;
    led_d     = led_q;
    emit      = 1'b0;
    res_d     = res_q;
    unique case (phase_q)
      PhIdle: begin
        if (byte_q == ipd_pkg::ChCr) phase_d = PhSkip;
      end
      PhSkip: begin
        if (byte_q == ipd_pkg::ChComma) begin
          phase_d   = PhCount;
          pay_rem_d = '0;
        end
      end
      PhCount: begin
        if (byte_q == ipd_pkg::ChColon) begin
          phase_d = (pay_rem_q == '0) ? PhIdle : PhPayload;
        end else begin
          // count * 10 + digit, modulo 256
          pay_rem_d = (pay_rem_q << 3) + (pay_rem_q << 1) + (byte_q - ipd_pkg::ChZero);
        end
      end
      PhPayload: begin
        pay_rem_d = rem_dec;
        if (rem_dec == '0) phase_d = PhIdle;
        if (exp_hdr_q) begin
          exp_len_d = byte_q;
          rcv_cnt_d = '0;
          if (byte_q == '0) begin
            // An empty message completes at once and leaves the LED alone.
            first_d = '0;
            emit    = 1'b1;
            res_d   = '{msg_type: '0, msg_length: '0, led_on: led_q};
          end else begin
            exp_hdr_d = 1'b0;
          end
        end else begin
          first_d   = first_now;
          rcv_cnt_d = cnt_inc;
          if (cnt_inc == exp_len_q) begin
            if (first_now == on_code_q) begin
              led_d = 1'b1;
            end else if (first_now == off_code_q) begin
              led_d = 1'b0;
            end
            exp_hdr_d = 1'b1;
            emit      = 1'b1;
            res_d     = '{msg_type: first_now, msg_length: exp_len_q, led_on: led_d};
          end
        end
      end
      default: phase_d = PhIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_code_q  <= ipd_pkg::OnCodeRst;
      off_code_q <= ipd_pkg::OffCodeRst;
      byte_vld_q <= 1'b0;
      phase_q    <= PhIdle;
      pay_rem_q  <= '0;
      exp_hdr_q  <= 1'b1;
      exp_len_q  <= '0;
      rcv_cnt_q  <= '0;
      first_q    <= '0;
      led_q      <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (ipd_pkg::cfg_idx_e'(cfg_idx_i))
          ipd_pkg::CfgOnCode:  on_code_q  <= cfg_wdata_i;
          ipd_pkg::CfgOffCode: off_code_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (rx.ready) byte_vld_q <= rx.valid;
      if (proc) begin
        phase_q   <= phase_d;
        pay_rem_q <= pay_rem_d;
        exp_hdr_q <= exp_hdr_d;
        exp_len_q <= exp_len_d;
        rcv_cnt_q <= rcv_cnt_d;
        first_q   <= first_d;
        led_q     <= led_d;
      end
      if (advance) res_vld_q <= proc && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx.valid && rx.ready) byte_q <= rx.rx_byte;
    if (proc && emit) res_q <= res_d;
  end

  assign tx.valid      = res_vld_q;
  assign tx.msg_type   = res_q.msg_type;
  assign tx.msg_length = res_q.msg_length;
  assign tx.led_on     = res_q.led_on;

`ifndef SYNTH
  // Inside a message the header is never zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exp_hdr_q |-> exp_len_q != '0)
    else $error("message in progress with zero length header");

  // The byte count stays below the header until the message completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exp_hdr_q |-> rcv_cnt_q < exp_len_q)
    else $error("message byte count reached its length without completing");

  // Payload phase always has bytes left to pass on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPayload |-> pay_rem_q != '0)
    else $error("payload phase with no bytes remaining");

  // An empty message reports a zero type.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx.valid && tx.msg_length == '0) |-> tx.msg_type == '0)
    else $error("empty message with nonzero type");

  // A result that waits is not overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && !tx.ready) |=> (res_vld_q && $stable(res_q)))
    else $error("stalled result changed");
`endif

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the length-prefixed message parser
// Sends framed link bytes (well-formed frames, noise and broken counts) under
// several code settings and idle mixes. A scoreboard predicts the completed
// messages and compares every tx transfer with the oldest one outstanding.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned LongHold     = 300;
  localparam logic [ipd_pkg::ByteW-1:0] Radix = 8'd10;

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhSkip    = 2'd1,
    PhCount   = 2'd2,
    PhPayload = 2'd3
  } frame_phase_e;

  // Tracks the parser and inner deframer state and keeps the messages that
  // the accepted bytes are due to produce, oldest first.
  class message_tracker;
    logic [ipd_pkg::ByteW-1:0] on_code;
    logic [ipd_pkg::ByteW-1:0] off_code;
    frame_phase_e              phase;
    logic [ipd_pkg::ByteW-1:0] payload_left;
    logic [ipd_pkg::ByteW-1:0] msg_len;
    logic [ipd_pkg::ByteW-1:0] msg_got;
    logic [ipd_pkg::ByteW-1:0] first_byte;
    logic                      want_header;
    logic                      led;
    ipd_pkg::result_t          pending_msgs[$];
    int unsigned               mismatches;
    int unsigned               checked;

    function new();
      on_code      = ipd_pkg::OnCodeRst;
      off_code     = ipd_pkg::OffCodeRst;
      phase        = PhIdle;
      payload_left = '0;
      msg_len      = '0;
      msg_got      = '0;
      first_byte   = '0;
      want_header  = 1'b1;
      led          = 1'b0;
      mismatches   = 0;
      checked      = 0;
    endfunction

    function void set_code(ipd_pkg::cfg_idx_e idx, logic [ipd_pkg::ByteW-1:0] value);
      if (idx == ipd_pkg::CfgOnCode) begin
        on_code = value;
      end else begin
        off_code = value;
      end
    endfunction

    function void take_byte(logic [ipd_pkg::ByteW-1:0] b);
      ipd_pkg::result_t msg;
      case (phase)
        PhIdle: begin
          if (b == ipd_pkg::ChCr) phase = PhSkip;
        end
        PhSkip: begin
          if (b == ipd_pkg::ChComma) begin
            phase        = PhCount;
            payload_left = '0;
          end
        end
        PhCount: begin
          if (b == ipd_pkg::ChColon) begin
            phase = (payload_left == '0) ? PhIdle : PhPayload;
          end else begin
            payload_left = payload_left * Radix + (b - ipd_pkg::ChZero);
          end
        end
        default: begin
          payload_left = payload_left - 1'b1;
          if (payload_left == '0) phase = PhIdle;
          if (want_header) begin
            msg_len = b;
            msg_got = '0;
            if (b == '0) begin
              // An empty message completes on its header and leaves the LED alone.
              first_byte     = '0;
              msg.msg_type   = '0;
              msg.msg_length = '0;
              msg.led_on     = led;
              pending_msgs.push_back(msg);
            end else begin
              want_header = 1'b0;
            end
          end else begin
            if (msg_got == '0) first_byte = b;
            msg_got = msg_got + 1'b1;
            if (msg_got == msg_len) begin
              if (first_byte == on_code) begin
                led = 1'b1;
              end else if (first_byte == off_code) begin
                led = 1'b0;
              end
              want_header    = 1'b1;
              msg.msg_type   = first_byte;
              msg.msg_length = msg_len;
              msg.led_on     = led;
              pending_msgs.push_back(msg);
            end
          end
        end
      endcase
    endfunction

    function void check_message(ipd_pkg::result_t got);
      ipd_pkg::result_t want;
      if (pending_msgs.size() == 0) begin
        $display("%0t: message with none expected: type %0h length %0d led %0b",
                 $time, got.msg_type, got.msg_length, got.led_on);
        mismatches++;
        return;
      end
      want = pending_msgs.pop_front();
      checked++;
      if (got.msg_type !== want.msg_type) begin
        $display("%0t: msg_type expected %0h actual %0h", $time, want.msg_type, got.msg_type);
        mismatches++;
      end
      if (got.msg_length !== want.msg_length) begin
        $display("%0t: msg_length expected %0d actual %0d", $time, want.msg_length,
                 got.msg_length);
        mismatches++;
      end
      if (got.led_on !== want.led_on) begin
        $display("%0t: led_on expected %0b actual %0b", $time, want.led_on, got.led_on);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_msgs.size();
    endfunction

    function int unsigned failures();
      return mismatches + pending_msgs.size();
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i;
  logic [0:0]                cfg_idx_i;
  logic [ipd_pkg::ByteW-1:0] cfg_wdata_i;

  ipd_in_if  rx_ch ();
  ipd_out_if tx_ch ();

  ipd_length_prefixed_message_parser i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx          (rx_ch),
    .tx          (tx_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  message_tracker            tracker;
  int unsigned               src_idle_pct;
  int unsigned               snk_idle_pct;
  int unsigned               stall_requests;
  int unsigned               stall_served;
  int unsigned               cycle_count;
  int unsigned               bytes_sent;
  int unsigned               frames_sent;
  logic [ipd_pkg::ByteW-1:0] cur_on;
  logic [ipd_pkg::ByteW-1:0] cur_off;
  int unsigned               stream_left;
  logic                      stream_first;
  logic                      want_long;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Both channels are sampled here, byte before message, with pre-edge values.
  always @(posedge clk_i) begin
    ipd_pkg::result_t got;
    if (rst_ni) begin
      if (rx_ch.valid && rx_ch.ready) tracker.take_byte(rx_ch.rx_byte);
      if (tx_ch.valid && tx_ch.ready) begin
        got.msg_type   = tx_ch.msg_type;
        got.msg_length = tx_ch.msg_length;
        got.led_on     = tx_ch.led_on;
        tracker.check_message(got);
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold whenever one is requested.
  initial begin
    tx_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_served != stall_requests) begin
        tx_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        stall_served++;
      end
      tx_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Next byte of a stream of well-formed inner messages: a length header, then
  // a type byte biased toward the LED codes, then random content.
  function automatic logic [ipd_pkg::ByteW-1:0] next_stream_byte();
    int unsigned               r;
    logic [ipd_pkg::ByteW-1:0] b;
    if (stream_left == 0) begin
      r = $urandom_range(99);
      if (want_long) begin
        stream_left = 255;
        want_long   = 1'b0;
      end else if (r < 12) begin
        stream_left = 0;
      end else if (r < 88) begin
        stream_left = $urandom_range(6, 1);
      end else begin
        stream_left = $urandom_range(40, 7);
      end
      stream_first = 1'b1;
      return 8'(stream_left);
    end
    r = $urandom_range(99);
    if (!stream_first || r >= 70) begin
      b = 8'($urandom_range(255));
    end else if (r < 35) begin
      b = cur_on;
    end else begin
      b = cur_off;
    end
    stream_first = 1'b0;
    stream_left--;
    return b;
  endfunction

  // Valid stays high after a transfer; the next call either offers a new byte
  // at once or opens a gap, so valid is assigned once per edge.
  task automatic offer_byte(input logic [ipd_pkg::ByteW-1:0] b);
    if ($urandom_range(99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk_i); while (!rx_ch.ready);
    bytes_sent++;
  endtask

  // One frame: optional noise, carriage return, skipped text, comma, decimal
  // count, colon and payload. A few frames are garbage, carry a stray byte in
  // the count, or are cut off before the colon. A forced count of zero or more
  // gives a well-formed frame with that count.
  task automatic send_frame(input int forced_count);
    int unsigned               kind;
    int unsigned               count;
    int unsigned               r;
    int unsigned               payload;
    logic [ipd_pkg::ByteW-1:0] b;
    kind = (forced_count >= 0) ? 99 : $urandom_range(99);
    frames_sent++;
    if (kind < 6) begin
      repeat ($urandom_range(8, 1)) offer_byte(8'($urandom_range(255)));
      return;
    end
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        b = 8'($urandom_range(255));
        if (b == ipd_pkg::ChCr) b = 8'hFF;
        offer_byte(b);
      end
    end
    offer_byte(ipd_pkg::ChCr);
    repeat ($urandom_range(4)) begin
      b = 8'($urandom_range(255));
      if (b == ipd_pkg::ChComma) b = 8'h00;
      offer_byte(b);
    end
    offer_byte(ipd_pkg::ChComma);
    if (forced_count >= 0) begin
      count = forced_count;
    end else begin
      r = $urandom_range(99);
      if (r < 3) begin
        count = $urandom_range(999, 256);
      end else if (r < 6) begin
        count = 0;
      end else if (r < 12) begin
        count = $urandom_range(60, 13);
      end else begin
        count = $urandom_range(12, 1);
      end
    end
    if ($urandom_range(9) == 0) offer_byte(ipd_pkg::ChZero);
    if (count >= 100) offer_byte(ipd_pkg::ChZero + 8'(count / 100));
    if (count >= 10) offer_byte(ipd_pkg::ChZero + 8'((count / 10) % 10));
    offer_byte(ipd_pkg::ChZero + 8'(count % 10));
    if (kind < 10) offer_byte(8'($urandom_range(255)));
    if (kind >= 10 && kind < 13) return;
    offer_byte(ipd_pkg::ChColon);
    payload = (kind < 10) ? $urandom_range(10) : count % 256;
    repeat (payload) offer_byte(next_stream_byte());
  endtask

  task automatic run_frames(input int unsigned budget);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < budget) send_frame(-1);
  endtask

  // Sender pause: nothing offered until every expected message is out and the
  // pipeline has had time to empty.
  task automatic settle();
    rx_ch.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes the on code and then the off code on consecutive edges.
  task automatic program_codes(input logic [ipd_pkg::ByteW-1:0] on_value,
                               input logic [ipd_pkg::ByteW-1:0] off_value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= ipd_pkg::CfgOnCode;
    cfg_wdata_i <= on_value;
    @(posedge clk_i);
    cfg_idx_i   <= ipd_pkg::CfgOffCode;
    cfg_wdata_i <= off_value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_code(ipd_pkg::CfgOnCode, on_value);
    tracker.set_code(ipd_pkg::CfgOffCode, off_value);
    cur_on  = on_value;
    cur_off = off_value;
  endtask

  initial begin
    logic [ipd_pkg::ByteW-1:0] directed[];
    directed = '{
      // Idle noise, a carriage return while skipping, and a zero count.
      8'hFF, ipd_pkg::ChCr, ipd_pkg::ChCr, ipd_pkg::ChComma, ipd_pkg::ChColon,
      // Empty message, then a type that matches the on code.
      ipd_pkg::ChCr, ipd_pkg::ChComma, 8'h33, ipd_pkg::ChColon, 8'h00, 8'h01, 8'h00,
      // A type that matches the off code.
      ipd_pkg::ChCr, ipd_pkg::ChComma, 8'h32, ipd_pkg::ChColon, 8'h01, 8'h01,
      // Count "24A" wraps to one through a non-digit byte.
      ipd_pkg::ChCr, ipd_pkg::ChComma, 8'h32, 8'h34, 8'h41, ipd_pkg::ChColon, 8'h00
    };
    tracker        = new();
    src_idle_pct   = 36;
    snk_idle_pct   = 54;
    stall_requests = 0;
    stall_served   = 0;
    cycle_count    = 0;
    bytes_sent     = 0;
    frames_sent    = 0;
    cur_on         = ipd_pkg::OnCodeRst;
    cur_off        = ipd_pkg::OffCodeRst;
    stream_left    = 0;
    stream_first   = 1'b0;
    want_long      = 1'b0;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= ipd_pkg::CfgOnCode;
    cfg_wdata_i   <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset codes, sender idles less than receiver.
    foreach (directed[i]) offer_byte(directed[i]);
    run_frames(80);
    stall_requests <= stall_requests + 1;
    run_frames(50);
    settle();
    run_frames(80);
    settle();

    // Extreme codes, idle mix swapped.
    program_codes(8'hFF, 8'h00);
    src_idle_pct = 54;
    snk_idle_pct = 36;
    run_frames(150);
    settle();

    // Equal codes, no idling, one maximum-length message.
    program_codes(8'h7E, 8'h7E);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    want_long    = 1'b1;
    send_frame(255);
    run_frames(130);
    settle();

    // Random codes.
    program_codes(8'($urandom_range(255)), 8'($urandom_range(255)));
    run_frames(150);
    settle();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d link bytes in %0d frames, with noise, broken counts and a long message.",
             bytes_sent, frames_sent);
    $display("Checked %0d messages under four code settings and three idle mixes.",
             tracker.checked);
    if (tracker.failures() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
